FILE: rtl/imte_pkg.sv
// Package for the infrared mark/space timing encoder.
// Holds widths, function and register codes, and the command control type.
// No dependencies; every other file of the block imports it.
package imte_pkg;

	localparam int MAX_BITS_DEF = 64;
	localparam int WORD_W       = 64;
	localparam int LEN_W        = 7;
	localparam int DUR_W        = 24;
	localparam int TC_W         = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_NEXT = 1'b1;

	localparam logic MODE_MANCHESTER = 1'b0;
	localparam logic MODE_PULSE      = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MARK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE     = 3'd7;

	// Classified request: load or next, plus the bit count used on a load.
	typedef struct packed {
		logic             is_load;
		logic [LEN_W-1:0] length;
	} cmd_ctl_t;

endpackage

FILE: rtl/imte_req_if.sv
// Request channel of the timing encoder: valid/ready plus the request fields.
// Depends on imte_pkg.
interface imte_req_if
	import imte_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              func;
	logic [WORD_W-1:0] message_word;
	logic [LEN_W-1:0]  message_length;

	modport source (output valid, func, message_word, message_length, input ready);
	modport sink   (input valid, func, message_word, message_length, output ready);
endinterface

FILE: rtl/imte_tim_if.sv
// Timing result channel of the encoder: valid/ready plus duration, level, frame end.
// Depends on imte_pkg.
interface imte_tim_if
	import imte_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [DUR_W-1:0] duration;
	logic             level;
	logic             frame_done;

	modport source (output valid, duration, level, frame_done, input ready);
	modport sink   (input valid, duration, level, frame_done, output ready);
endinterface

FILE: rtl/imte_front.sv
// Front stage: accepts requests, classifies them as load or next and
// registers them for the command queue. Depends on imte_pkg and imte_req_if.
module imte_front
	import imte_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	imte_req_if.sink            request,
	output logic                push,
	input  logic                push_ready,
	output cmd_ctl_t            ctl,
	output logic [MAX_BITS-1:0] msg
);

	logic                valid_s1;
	cmd_ctl_t            ctl_s1;
	logic [MAX_BITS-1:0] msg_s1;
	logic                take;

	assign request.ready = !valid_s1 || push_ready;
	assign take          = request.valid && request.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1.is_load <= (request.func == FUNC_LOAD);
			ctl_s1.length  <= request.message_length;
			msg_s1         <= request.message_word[MAX_BITS-1:0];
		end
	end

	assign push = valid_s1;
	assign ctl  = ctl_s1;
	assign msg  = msg_s1;

endmodule

FILE: rtl/imte_queue.sv
// Short command queue between the front and back stages.
// Generic packed payload; depends on imte_pkg for the depth.
module imte_queue
	import imte_pkg::*;
#(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              head_valid,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
		else $error("pop without push did not lower the count");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(QUEUE_DEPTH) && !do_pop) |=> $stable(wr_ptr_q))
		else $error("write pointer moved while full");

endmodule

FILE: rtl/imte_back.sv
// Back stage: holds the configuration registers and the frame state, carries
// out load and next commands and drives the registered timing output.
// Depends on imte_pkg and imte_tim_if.
module imte_back
	import imte_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  head_valid,
	input  cmd_ctl_t              head_ctl,
	input  logic [MAX_BITS-1:0]   head_msg,
	output logic                  pop,
	imte_tim_if.source            timing
);

	localparam logic [1:0] PH_SILENCE  = 2'd0;
	localparam logic [1:0] PH_PREAMBLE = 2'd1;
	localparam logic [1:0] PH_ENCODE   = 2'd2;

	localparam int IDX_W = $clog2(MAX_BITS);
	localparam int PAD_W = 1 << IDX_W;

	// Configuration registers.
	logic             mode_q;
	logic [DUR_W-1:0] silence_q;
	logic [DUR_W-1:0] pre_mark_q;
	logic [DUR_W-1:0] pre_space_q;
	logic [DUR_W-1:0] one_mark_q;
	logic [DUR_W-1:0] one_space_q;
	logic [DUR_W-1:0] zero_mark_q;
	logic [DUR_W-1:0] zero_space_q;

	// Frame state.
	logic [1:0]          phase_q;
	logic [TC_W-1:0]     tc_q;
	logic [LEN_W-1:0]    bits_q;
	logic [MAX_BITS-1:0] msg_q;
	logic [LEN_W-1:0]    len_q;

	// Output register.
	logic             out_valid_q;
	logic [DUR_W-1:0] out_dur_q;
	logic             out_lvl_q;
	logic             out_done_q;

	logic             can_issue;
	logic             issue_next;
	logic             issue_load;
	logic [PAD_W-1:0] msg_pad;
	logic             bit_v;
	logic             odd;
	logic             pwm;
	logic [LEN_W-1:0] bits_inc;
	logic [DUR_W-1:0] nx_dur;
	logic             nx_lvl;
	logic             nx_done;
	logic [1:0]       nx_phase;
	logic [TC_W-1:0]  nx_tc;
	logic [LEN_W-1:0] nx_bits;

	assign can_issue  = !out_valid_q || timing.ready;
	assign pop        = head_valid && (head_ctl.is_load || can_issue);
	assign issue_load = pop && head_ctl.is_load;
	assign issue_next = pop && !head_ctl.is_load;

	assign msg_pad  = PAD_W'(msg_q);
	assign bit_v    = (bits_q < LEN_W'(MAX_BITS)) && msg_pad[bits_q[IDX_W-1:0]];
	assign odd      = tc_q[0];
	assign pwm      = (one_space_q == zero_space_q);
	assign bits_inc = bits_q + 1'b1;

	always_comb begin
		nx_dur   = '0;
		nx_lvl   = 1'b0;
		nx_done  = 1'b0;
		nx_phase = phase_q;
		nx_tc    = tc_q + 1'b1;
		nx_bits  = bits_q;
		if (phase_q == PH_SILENCE) begin
			nx_dur   = silence_q;
			nx_phase = PH_PREAMBLE;
		end else if (phase_q == PH_PREAMBLE && pre_mark_q != '0) begin
			if (tc_q == TC_W'(1)) begin
				nx_dur = pre_mark_q;
				nx_lvl = 1'b1;
			end else begin
				nx_dur   = pre_space_q;
				nx_phase = PH_ENCODE;
			end
		end else begin
			nx_phase = PH_ENCODE;
			if (mode_q == MODE_MANCHESTER) begin
				// First half of a bit carries the bit value itself; the second half carries its inverse.
				// The early count on the last half never wraps the counter to the length.
				nx_lvl = !odd ^ bit_v;
				nx_dur = one_mark_q;
				if (!odd || (nx_lvl && bits_q != '1 && bits_inc == len_q)) begin
					nx_bits = bits_inc;
				end
			end else if (odd) begin
				nx_dur = bit_v ? one_mark_q : zero_mark_q;
				nx_lvl = 1'b1;
				if (pwm) begin
					nx_bits = bits_inc;
				end
			end else begin
				nx_dur = bit_v ? one_space_q : zero_space_q;
				if (!pwm) begin
					nx_bits = bits_inc;
				end
			end
			if (nx_bits == len_q && nx_lvl) begin
				nx_done  = 1'b1;
				nx_phase = PH_SILENCE;
				nx_tc    = '0;
				nx_bits  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_MANCHESTER;
			silence_q    <= '0;
			pre_mark_q   <= '0;
			pre_space_q  <= '0;
			one_mark_q   <= '0;
			one_space_q  <= '0;
			zero_mark_q  <= '0;
			zero_space_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CODING_MODE:    mode_q       <= cfg_data[0];
				REG_SILENCE:        silence_q    <= cfg_data;
				REG_PREAMBLE_MARK:  pre_mark_q   <= cfg_data;
				REG_PREAMBLE_SPACE: pre_space_q  <= cfg_data;
				REG_ONE_MARK:       one_mark_q   <= cfg_data;
				REG_ONE_SPACE:      one_space_q  <= cfg_data;
				REG_ZERO_MARK:      zero_mark_q  <= cfg_data;
				REG_ZERO_SPACE:     zero_space_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SILENCE;
			tc_q    <= '0;
			bits_q  <= '0;
			msg_q   <= '0;
			len_q   <= '0;
		end else if (issue_load) begin
			phase_q <= PH_SILENCE;
			tc_q    <= '0;
			bits_q  <= '0;
			msg_q   <= head_msg;
			len_q   <= head_ctl.length;
		end else if (issue_next) begin
			phase_q <= nx_phase;
			tc_q    <= nx_tc;
			bits_q  <= nx_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_issue) begin
			out_valid_q <= issue_next;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_next) begin
			out_dur_q  <= nx_dur;
			out_lvl_q  <= nx_lvl;
			out_done_q <= nx_done;
		end
	end

	assign timing.valid      = out_valid_q;
	assign timing.duration   = out_dur_q;
	assign timing.level      = out_lvl_q;
	assign timing.frame_done = out_done_q;

	a_done_is_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> out_lvl_q)
		else $error("frame end flagged on a space");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		issue_next && nx_done |=> phase_q == PH_SILENCE && bits_q == '0)
		else $error("encoder did not return to silence after frame end");

	a_silence_space: assert property (@(posedge clk) disable iff (!arst_n)
		issue_next && phase_q == PH_SILENCE |=> out_valid_q && !out_lvl_q && !out_done_q)
		else $error("silence timing is not a plain space");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		issue_load && out_valid_q && !timing.ready |=> out_valid_q && $stable(out_dur_q))
		else $error("load disturbed a waiting timing");

endmodule

FILE: rtl/ir_mark_space_timing_encoder.sv
// Infrared mark/space timing encoder, top level.
// A next request's timing goes through the front register (loaded at acceptance), then
// the command queue, then the back output register. Throughput: one request per cycle
// unless timing.ready stalls the output, set by the bit select and counter update.
// Reset (arst_n, asynchronous) clears configuration, frame state, message and queue.
module ir_mark_space_timing_encoder
	import imte_pkg::*;
#(
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	imte_req_if.sink              request,
	imte_tim_if.source            timing
);

	localparam int CTL_W = $bits(cmd_ctl_t);
	localparam int Q_W   = CTL_W + MAX_BITS;

	logic                push;
	logic                push_ready;
	cmd_ctl_t            push_ctl;
	logic [MAX_BITS-1:0] push_msg;
	logic                head_valid;
	logic                pop;
	logic [Q_W-1:0]      head_data;
	cmd_ctl_t            head_ctl;
	logic [MAX_BITS-1:0] head_msg;

	imte_front #(.MAX_BITS(MAX_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.push       (push),
		.push_ready (push_ready),
		.ctl        (push_ctl),
		.msg        (push_msg)
	);

	imte_queue #(.DATA_W(Q_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  ({push_ctl, push_msg}),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	assign head_ctl = head_data[Q_W-1:MAX_BITS];
	assign head_msg = head_data[MAX_BITS-1:0];

	imte_back #(.MAX_BITS(MAX_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_ctl   (head_ctl),
		.head_msg   (head_msg),
		.pop        (pop),
		.timing     (timing)
	);

endmodule
